[rtl/rational_arithmetic_unit_core_defines.svh]
// Shared assertion macros
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// property holds in the cycle after the trigger
`define RAU_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

// property holds in the same cycle as the trigger
`define RAU_ASSERT_NOW(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error(msg);

`endif

[rtl/rau_pkg.sv]
package rau_pkg;

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_MUL = 4'd2,
    MODE_DIV = 4'd3,
    MODE_RED = 4'd4,
    MODE_CMP = 4'd5,
    MODE_MIN = 4'd6,
    MODE_MAX = 4'd7,
    MODE_ABS = 4'd8
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_OP_MUL1,
    ST_OP_MUL2,
    ST_OP_MUL3,
    ST_OP_COMB,
    ST_RES_RED,
    ST_FINISH,
    ST_OUT
  } state_e;

  // gcd/divide unit states
  typedef enum logic [2:0] {
    RED_IDLE,
    RED_GCD,
    RED_REM,
    RED_DIVM,
    RED_DIVD,
    RED_DONE
  } red_state_e;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_RED_START_A,
    CMD_RED_START_B,
    CMD_RED_START_R,
    CMD_MUL1,
    CMD_MUL2,
    CMD_MUL3,
    CMD_COMB,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic red_busy;
    logic red_done;
    logic err;
    logic uses_b;
    logic valid_mode;
    logic res_is_reduced;
  } stat_t;

endpackage

[rtl/rau_if.sv]
interface rau_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;
  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic        is_less;
  logic        is_equal;
  logic        is_greater;
  logic        zero_den_error;
  logic        overflow;
  modport source (output valid, res_num, res_den, is_less, is_equal, is_greater,
                  zero_den_error, overflow, input ready);
  modport sink (input valid, res_num, res_den, is_less, is_equal, is_greater,
                zero_den_error, overflow, output ready);
endinterface

[rtl/rational_arithmetic_unit_core.sv]
// Channel  Dir  Payload
// in_if    in   mode, a_num, a_den, b_num, b_den
// out_if   out  res_num, res_den, is_less/equal/greater, zero_den_error, overflow
// One request at a time, paced by the shared gcd/divide unit: each reduction runs
// the Euclid steps, then two quotient divisions (one remainder bit per cycle).
// Up to three reductions per request; unused modes skip the reductions.
// Reset is asynchronous, active low; the unit returns to idle.
// The result holds on out_if until taken; no new request is taken meanwhile.
module rational_arithmetic_unit_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  rau_in_if.sink    in_if,
  rau_out_if.source out_if
);

  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .ctrl_o     (ctrl),
    .stat_i     (stat)
  );

  rau_datapath #(.OperandWidth(OPERAND_WIDTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .mode_i          (in_if.mode),
    .a_num_i         (in_if.a_num),
    .a_den_i         (in_if.a_den),
    .b_num_i         (in_if.b_num),
    .b_den_i         (in_if.b_den),
    .res_num_o       (out_if.res_num),
    .res_den_o       (out_if.res_den),
    .is_less_o       (out_if.is_less),
    .is_equal_o      (out_if.is_equal),
    .is_greater_o    (out_if.is_greater),
    .zero_den_error_o(out_if.zero_den_error),
    .overflow_o      (out_if.overflow)
  );

endmodule

[rtl/rau_reducer.sv]
// Divides mag and den by their gcd: Euclid with a radix-2 restoring remainder,
// then two restoring quotient divisions.
module rau_reducer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] mag_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] mag_o,
  output logic [63:0] den_o
);

  rau_pkg::red_state_e st_q, st_d;
  logic [63:0] x_q, x_d, y_q, y_d;
  logic [63:0] m_q, m_d, d_q, d_d;
  logic [63:0] rem_q, rem_d, quo_q, quo_d, sh_q, sh_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;
  logic [64:0] rshift;

  assign rshift = {rem_q, sh_q[63]};
  assign trial  = rshift - {1'b0, y_q};

  always_comb begin
    st_d  = st_q;
    x_d   = x_q;
    y_d   = y_q;
    m_d   = m_q;
    d_d   = d_q;
    rem_d = rem_q;
    quo_d = quo_q;
    sh_d  = sh_q;
    cnt_d = cnt_q;
    unique case (st_q)
      rau_pkg::RED_IDLE: begin
        if (start_i) begin
          m_d  = mag_i;
          d_d  = den_i;
          x_d  = mag_i;
          y_d  = den_i;
          st_d = rau_pkg::RED_GCD;
        end
      end
      rau_pkg::RED_GCD: begin
        if (y_q == '0) begin
          // x_q holds the gcd; divide mag first
          sh_d  = m_q;
          rem_d = '0;
          quo_d = '0;
          cnt_d = '0;
          y_d   = x_q;
          st_d  = rau_pkg::RED_DIVM;
        end else begin
          sh_d  = x_q;
          rem_d = '0;
          cnt_d = '0;
          st_d  = rau_pkg::RED_REM;
        end
      end
      rau_pkg::RED_REM, rau_pkg::RED_DIVM, rau_pkg::RED_DIVD: begin
        if (!trial[64]) begin
          rem_d = trial[63:0];
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rshift[63:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
        sh_d  = {sh_q[62:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          if (st_q == rau_pkg::RED_REM) begin
            x_d  = y_q;
            y_d  = rem_d;
            st_d = rau_pkg::RED_GCD;
          end else if (st_q == rau_pkg::RED_DIVM) begin
            m_d   = quo_d;
            sh_d  = d_q;
            rem_d = '0;
            quo_d = '0;
            cnt_d = '0;
            st_d  = rau_pkg::RED_DIVD;
          end else begin
            d_d  = quo_d;
            st_d = rau_pkg::RED_DONE;
          end
        end
      end
      rau_pkg::RED_DONE: st_d = rau_pkg::RED_IDLE;
      default: st_d = rau_pkg::RED_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= rau_pkg::RED_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
    d_q   <= d_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sh_q  <= sh_d;
  end

  assign busy_o = (st_q != rau_pkg::RED_IDLE);
  assign done_o = (st_q == rau_pkg::RED_DONE);
  assign mag_o  = m_q;
  assign den_o  = d_q;

endmodule

[rtl/rau_datapath.sv]
`include "rational_arithmetic_unit_core_defines.svh"

module rau_datapath #(
  parameter int OperandWidth = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rau_pkg::ctrl_t ctrl_i,
  output rau_pkg::stat_t stat_o,
  input  logic [3:0]   mode_i,
  input  logic [31:0]  a_num_i,
  input  logic [31:0]  a_den_i,
  input  logic [31:0]  b_num_i,
  input  logic [31:0]  b_den_i,
  output logic [31:0]  res_num_o,
  output logic [30:0]  res_den_o,
  output logic         is_less_o,
  output logic         is_equal_o,
  output logic         is_greater_o,
  output logic         zero_den_error_o,
  output logic         overflow_o
);

  localparam logic [63:0] Lim = 64'd1 << (OperandWidth - 1);

  logic [3:0]  mode_q;
  logic [31:0] an_q, ad_q, bn_q, bd_q;
  logic        a_neg_q, b_neg_q, r_neg_q;
  logic [63:0] a_mag_q, a_den_q, b_mag_q, b_den_q;
  logic [63:0] p_q, q_q, dd_q, r_mag_q, r_den_q;
  logic        err_q, lt_q, eq_q, gt_q;
  logic        reduced_q;
  logic [31:0] rn_q;
  logic [30:0] rd_q;
  logic        ovf_q;

  logic        red_start, red_busy, red_done;
  logic [63:0] red_mag_in, red_den_in, red_mag, red_den;

  logic        sgn_an, sgn_ad, sgn_bn, sgn_bd;
  logic [31:0] mag_an, mag_ad, mag_bn, mag_bd;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  logic        uses_b, valid_mode;
  logic        pn, qn;
  logic        p_lt, p_gt;
  logic        cmp_fin;

  function automatic logic [31:0] op_mag(input logic [31:0] v);
    logic [31:0] t;
    t = v & ((32'd1 << OperandWidth) - 32'd1);
    if (t[OperandWidth-1]) t = ((32'd1 << OperandWidth) - 32'd1) - t + 32'd1;
    return t;
  endfunction

  assign sgn_an = an_q[OperandWidth-1];
  assign sgn_ad = ad_q[OperandWidth-1];
  assign sgn_bn = bn_q[OperandWidth-1];
  assign sgn_bd = bd_q[OperandWidth-1];
  assign mag_an = op_mag(an_q);
  assign mag_ad = op_mag(ad_q);
  assign mag_bn = op_mag(bn_q);
  assign mag_bd = op_mag(bd_q);

  assign valid_mode = (mode_q <= 4'(rau_pkg::MODE_ABS));
  assign uses_b = (mode_q <= 4'(rau_pkg::MODE_DIV)) ||
                  (mode_q >= 4'(rau_pkg::MODE_CMP) && mode_q <= 4'(rau_pkg::MODE_MAX));

  // one shared 32x32 multiplier, registered on each use
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (ctrl_i.cmd)
      rau_pkg::CMD_MUL1: begin
        mul_x = a_mag_q[31:0];
        mul_y = (mode_q == 4'(rau_pkg::MODE_MUL)) ? b_mag_q[31:0] : b_den_q[31:0];
      end
      rau_pkg::CMD_MUL2: begin
        mul_x = a_den_q[31:0];
        mul_y = (mode_q == 4'(rau_pkg::MODE_MUL)) ? b_den_q[31:0] : b_mag_q[31:0];
      end
      rau_pkg::CMD_MUL3: begin
        mul_x = a_den_q[31:0];
        mul_y = b_den_q[31:0];
      end
      default: ;
    endcase
  end
  assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

  assign pn   = a_neg_q;
  assign qn   = b_neg_q ^ (mode_q == 4'(rau_pkg::MODE_SUB));
  // signed compare of (+-p) vs (+-q); zero magnitudes have neg cleared
  always_comb begin
    p_lt = 1'b0;
    p_gt = 1'b0;
    if (a_neg_q && !b_neg_q) p_lt = 1'b1;
    else if (!a_neg_q && b_neg_q) p_gt = 1'b1;
    else if (!a_neg_q) begin
      p_lt = p_q < q_q;
      p_gt = p_q > q_q;
    end else begin
      p_lt = p_q > q_q;
      p_gt = p_q < q_q;
    end
  end

  always_comb begin
    red_start  = 1'b0;
    red_mag_in = '0;
    red_den_in = '0;
    unique case (ctrl_i.cmd)
      rau_pkg::CMD_RED_START_A: begin
        red_start  = 1'b1;
        red_mag_in = {32'd0, mag_an};
        red_den_in = {32'd0, mag_ad};
      end
      rau_pkg::CMD_RED_START_B: begin
        red_start  = 1'b1;
        red_mag_in = {32'd0, mag_bn};
        red_den_in = {32'd0, mag_bd};
      end
      rau_pkg::CMD_RED_START_R: begin
        red_start  = 1'b1;
        red_mag_in = r_mag_q;
        red_den_in = r_den_q;
      end
      default: ;
    endcase
  end

  rau_reducer u_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(red_start),
    .mag_i  (red_mag_in),
    .den_i  (red_den_in),
    .busy_o (red_busy),
    .done_o (red_done),
    .mag_o  (red_mag),
    .den_o  (red_den)
  );

  logic [1:0] red_tgt_q;
  logic [64:0] sum;
  assign sum = {1'b0, p_q} + {1'b0, q_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q     <= 1'b0;
      red_tgt_q <= '0;
      reduced_q <= 1'b0;
    end else begin
      unique case (ctrl_i.cmd)
        rau_pkg::CMD_CAPTURE: begin
          err_q     <= 1'b0;
          reduced_q <= 1'b0;
        end
        rau_pkg::CMD_RED_START_A: begin
          red_tgt_q <= 2'd0;
          if (mag_ad == '0) err_q <= 1'b1;
        end
        rau_pkg::CMD_RED_START_B: begin
          red_tgt_q <= 2'd1;
          if (mag_bd == '0) err_q <= 1'b1;
        end
        rau_pkg::CMD_RED_START_R: begin
          red_tgt_q <= 2'd2;
          reduced_q <= 1'b1;
          if (r_den_q == '0) err_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      rau_pkg::CMD_CAPTURE: begin
        mode_q <= mode_i;
        an_q   <= a_num_i;
        ad_q   <= a_den_i;
        bn_q   <= b_num_i;
        bd_q   <= b_den_i;
        a_neg_q <= 1'b0;
        a_mag_q <= '0;
        a_den_q <= 64'd1;
        b_neg_q <= 1'b0;
        b_mag_q <= '0;
        b_den_q <= 64'd1;
        lt_q <= 1'b0;
        eq_q <= 1'b0;
        gt_q <= 1'b0;
      end
      rau_pkg::CMD_RED_START_A: a_neg_q <= (sgn_an ^ sgn_ad) && (mag_an != '0);
      rau_pkg::CMD_RED_START_B: b_neg_q <= (sgn_bn ^ sgn_bd) && (mag_bn != '0);
      rau_pkg::CMD_MUL1: p_q  <= mul_p;
      rau_pkg::CMD_MUL2: q_q  <= mul_p;
      rau_pkg::CMD_MUL3: dd_q <= mul_p;
      rau_pkg::CMD_COMB: begin
        unique case (mode_q)
          4'(rau_pkg::MODE_ADD), 4'(rau_pkg::MODE_SUB): begin
            r_den_q <= dd_q;
            if (pn == qn) begin
              r_neg_q <= pn;
              r_mag_q <= sum[63:0];
            end else if (p_q >= q_q) begin
              r_neg_q <= pn;
              r_mag_q <= p_q - q_q;
            end else begin
              r_neg_q <= qn;
              r_mag_q <= q_q - p_q;
            end
          end
          4'(rau_pkg::MODE_MUL), 4'(rau_pkg::MODE_DIV): begin
            r_neg_q <= a_neg_q ^ b_neg_q;
            r_mag_q <= p_q;
            r_den_q <= q_q;
          end
          4'(rau_pkg::MODE_CMP): begin
            lt_q <= p_lt;
            eq_q <= !p_lt && !p_gt;
            gt_q <= p_gt;
            r_neg_q <= 1'b0;
            r_mag_q <= '0;
            r_den_q <= 64'd1;
          end
          4'(rau_pkg::MODE_MIN): begin
            r_neg_q <= p_lt ? a_neg_q : b_neg_q;
            r_mag_q <= p_lt ? a_mag_q : b_mag_q;
            r_den_q <= p_lt ? a_den_q : b_den_q;
          end
          4'(rau_pkg::MODE_MAX): begin
            r_neg_q <= p_gt ? a_neg_q : b_neg_q;
            r_mag_q <= p_gt ? a_mag_q : b_mag_q;
            r_den_q <= p_gt ? a_den_q : b_den_q;
          end
          default: begin
            r_neg_q <= a_neg_q && (mode_q != 4'(rau_pkg::MODE_ABS));
            r_mag_q <= a_mag_q;
            r_den_q <= a_den_q;
          end
        endcase
      end
      rau_pkg::CMD_FINISH: begin
        rn_q  <= '0;
        rd_q  <= 31'd1;
        ovf_q <= 1'b0;
        if (valid_mode && !err_q && mode_q != 4'(rau_pkg::MODE_CMP)) begin
          if (((r_neg_q ? (r_mag_q <= Lim) : (r_mag_q < Lim))) && (r_den_q < Lim)) begin
            rn_q <= r_neg_q ? (32'd0 - r_mag_q[31:0]) : r_mag_q[31:0];
            rd_q <= r_den_q[30:0];
          end else begin
            ovf_q <= 1'b1;
          end
        end
        if (err_q) begin
          lt_q <= 1'b0;
          eq_q <= 1'b0;
          gt_q <= 1'b0;
        end
      end
      default: ;
    endcase
    if (red_done) begin
      unique case (red_tgt_q)
        2'd0: begin
          a_mag_q <= red_mag;
          a_den_q <= red_den;
        end
        2'd1: begin
          b_mag_q <= red_mag;
          b_den_q <= red_den;
        end
        default: begin
          r_mag_q <= red_mag;
          r_den_q <= red_den;
          if (red_mag == '0) r_neg_q <= 1'b0;
        end
      endcase
    end
  end

  assign cmp_fin = (ctrl_i.cmd == rau_pkg::CMD_FINISH) && !err_q &&
                   (mode_q == 4'(rau_pkg::MODE_CMP));

  assign stat_o.red_busy       = red_busy;
  assign stat_o.red_done       = red_done;
  assign stat_o.err            = err_q;
  assign stat_o.uses_b         = uses_b;
  assign stat_o.valid_mode     = valid_mode;
  assign stat_o.res_is_reduced = reduced_q;

  assign res_num_o        = rn_q;
  assign res_den_o        = rd_q;
  assign is_less_o        = lt_q;
  assign is_equal_o       = eq_q;
  assign is_greater_o     = gt_q;
  assign zero_den_error_o = err_q;
  assign overflow_o       = ovf_q;

  `RAU_ASSERT_NEXT(a_red_start_busy, clk_i, rst_ni, red_start, red_busy, "reducer did not start")
  `RAU_ASSERT_NOW(a_cmp_onehot, clk_i, rst_ni, cmp_fin, $onehot({p_lt, !p_lt && !p_gt, p_gt}), "compare not one-hot")
  `RAU_ASSERT_NOW(a_no_start_busy, clk_i, rst_ni, red_start, !red_busy, "reducer restarted while busy")

endmodule

[rtl/rau_ctrl.sv]
`include "rational_arithmetic_unit_core_defines.svh"

module rau_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rau_pkg::ctrl_t ctrl_o,
  input  rau_pkg::stat_t stat_i
);

  rau_pkg::state_e st_q, st_d;
  logic            wait_q, wait_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= rau_pkg::ST_IDLE;
      wait_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      wait_q <= wait_d;
    end
  end

  always_comb begin
    st_d        = st_q;
    wait_d      = wait_q;
    ctrl_o.cmd  = rau_pkg::CMD_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (st_q)
      rau_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cmd = rau_pkg::CMD_CAPTURE;
          st_d       = rau_pkg::ST_LOAD_A;
          wait_d     = 1'b0;
        end
      end
      rau_pkg::ST_LOAD_A: begin
        if (!stat_i.valid_mode) begin
          st_d = rau_pkg::ST_FINISH;
        end else if (!wait_q) begin
          ctrl_o.cmd = rau_pkg::CMD_RED_START_A;
          wait_d     = 1'b1;
        end else if (stat_i.red_done) begin
          wait_d = 1'b0;
          if (stat_i.err) st_d = rau_pkg::ST_FINISH;
          else if (stat_i.uses_b) st_d = rau_pkg::ST_LOAD_B;
          else st_d = rau_pkg::ST_OP_COMB;
        end
      end
      rau_pkg::ST_LOAD_B: begin
        if (!wait_q) begin
          ctrl_o.cmd = rau_pkg::CMD_RED_START_B;
          wait_d     = 1'b1;
        end else if (stat_i.red_done) begin
          wait_d = 1'b0;
          st_d   = stat_i.err ? rau_pkg::ST_FINISH : rau_pkg::ST_OP_MUL1;
        end
      end
      rau_pkg::ST_OP_MUL1: begin
        ctrl_o.cmd = rau_pkg::CMD_MUL1;
        st_d       = rau_pkg::ST_OP_MUL2;
      end
      rau_pkg::ST_OP_MUL2: begin
        ctrl_o.cmd = rau_pkg::CMD_MUL2;
        st_d       = rau_pkg::ST_OP_MUL3;
      end
      rau_pkg::ST_OP_MUL3: begin
        ctrl_o.cmd = rau_pkg::CMD_MUL3;
        st_d       = rau_pkg::ST_OP_COMB;
      end
      rau_pkg::ST_OP_COMB: begin
        ctrl_o.cmd = rau_pkg::CMD_COMB;
        st_d       = rau_pkg::ST_RES_RED;
      end
      rau_pkg::ST_RES_RED: begin
        if (!wait_q) begin
          ctrl_o.cmd = rau_pkg::CMD_RED_START_R;
          wait_d     = 1'b1;
        end else if (stat_i.red_done) begin
          wait_d = 1'b0;
          st_d   = rau_pkg::ST_FINISH;
        end
      end
      rau_pkg::ST_FINISH: begin
        ctrl_o.cmd = rau_pkg::CMD_FINISH;
        wait_d     = 1'b0;
        st_d       = rau_pkg::ST_OUT;
      end
      rau_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) st_d = rau_pkg::ST_IDLE;
      end
      default: st_d = rau_pkg::ST_IDLE;
    endcase
  end

  `RAU_ASSERT_NOW(a_ready_only_idle, clk_i, rst_ni, in_ready_o, st_q == rau_pkg::ST_IDLE, "ready outside idle")
  `RAU_ASSERT_NEXT(a_accept_loads, clk_i, rst_ni, in_valid_i && in_ready_o, st_q == rau_pkg::ST_LOAD_A, "accept did not load")
  `RAU_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o, "overlap of request and result")

endmodule
